/* hdl/padded_integer_formatter_core_assert.svh */
// Assertion macros for the padded integer formatter.
// Included by the files that check their own logic; needs no package.
`ifndef PADDED_INTEGER_FORMATTER_CORE_ASSERT_SVH
`define PADDED_INTEGER_FORMATTER_CORE_ASSERT_SVH

`ifndef SYNTH
`define PIF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PIF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PIF_ASSERT(label, clk, rst_n, prop, msg)
`define PIF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hdl/pif_pkg.sv */
// Shared types, constants and helpers of the padded integer formatter.
// No dependencies; every module refers to it by scoped names.
package pif_pkg;

    localparam int MAX_FIELD_WIDTH = 63;
    localparam int VALUE_W         = 64;
    localparam int WIDTH_W         = 6;
    localparam int NUM_DIGITS      = 20;
    localparam int DIGIT_BUS_W     = NUM_DIGITS * 4;
    localparam int NDIG_W          = 5;
    localparam int S_TDATA_W       = 80;
    localparam int M_TDATA_W       = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int Q_PTR_W         = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_MINUS   = 8'h2d;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    // 'a' minus ten, so that a hex digit of ten or more maps onto 'a'..'f'.
    localparam logic [7:0] CHAR_ALPHA_OFS = 8'h57;

    typedef struct packed {
        logic [DIGIT_BUS_W-1:0] digits;     // nibbles, least significant digit lowest
        logic [NDIG_W-1:0]      num_digits;
        logic                   neg;
        logic [WIDTH_W-1:0]     pad;
        logic                   zero_fill;
    } fmt_desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + {4'b0000, d};
        end
        else
        begin
            c = CHAR_ALPHA_OFS + {4'b0000, d};
        end
        return c;
    endfunction

endpackage

/* hdl/pif_front.sv */
// Front part: accepts a value, converts it to decimal or hex digits and
// works out sign and padding. Uses pif_pkg; feeds pif_queue.
module pif_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // value[63:0], hex_mode[64], signed_mode[65], min_width[71:66], zero_fill[72]
    input  logic [pif_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                               q_push,
    output pif_pkg::fmt_desc_t                 q_desc,
    input  pif_pkg::q_status_t                 q_stat
);

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_CONV = 2'd1;
    localparam logic [1:0] FS_FIN  = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic [pif_pkg::VALUE_W-1:0]       mag_reg, mag_next;
    logic [pif_pkg::DIGIT_BUS_W-1:0]   bcd_reg, bcd_next;
    logic [5:0]                        bit_cnt_reg, bit_cnt_next;
    logic                              neg_reg, neg_next;
    logic [pif_pkg::WIDTH_W-1:0]       width_reg, width_next;
    logic                              zfill_reg, zfill_next;

    logic [pif_pkg::VALUE_W-1:0]       in_value;
    logic                              in_hex;
    logic                              in_signed;
    logic [pif_pkg::WIDTH_W-1:0]       in_width;
    logic                              in_zfill;
    logic                              in_neg;
    logic [pif_pkg::VALUE_W-1:0]       in_mag;
    logic [pif_pkg::DIGIT_BUS_W-1:0]   bcd_adj;
    logic [pif_pkg::NDIG_W-1:0]        num_digits;
    logic [pif_pkg::WIDTH_W-1:0]       width_clamped;
    logic [pif_pkg::WIDTH_W-1:0]       base_total;
    logic [pif_pkg::WIDTH_W-1:0]       pad;

    assign in_value  = s_tdata[63:0];
    assign in_hex    = s_tdata[64];
    assign in_signed = s_tdata[65];
    assign in_width  = s_tdata[71:66];
    assign in_zfill  = s_tdata[72];
    assign in_neg    = in_signed & in_value[pif_pkg::VALUE_W-1];
    assign in_mag    = in_neg ? (~in_value + 64'd1) : in_value;

    assign s_tready = (state_reg == FS_IDLE);

    // Shift-and-add-3 step: every BCD digit of five or more is corrected
    // before the next magnitude bit is shifted in.
    always_comb
    begin
        for (int i = 0; i < pif_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    // Digit count is the position of the highest nonzero digit; zero has one digit.
    always_comb
    begin
        num_digits = pif_pkg::NDIG_W'(1);
        for (int i = 0; i < pif_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
            begin
                num_digits = pif_pkg::NDIG_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        if (width_reg > pif_pkg::WIDTH_W'(pif_pkg::MAX_FIELD_WIDTH))
        begin
            width_clamped = pif_pkg::WIDTH_W'(pif_pkg::MAX_FIELD_WIDTH);
        end
        else
        begin
            width_clamped = width_reg;
        end
        base_total = {1'b0, num_digits} + {5'b00000, neg_reg};
        if (width_clamped > base_total)
        begin
            pad = width_clamped - base_total;
        end
        else
        begin
            pad = '0;
        end
    end

    assign q_desc.digits     = bcd_reg;
    assign q_desc.num_digits = num_digits;
    assign q_desc.neg        = neg_reg;
    assign q_desc.pad        = pad;
    assign q_desc.zero_fill  = zfill_reg;
    assign q_push            = (state_reg == FS_FIN) && !q_stat.full;

    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        neg_next     = neg_reg;
        width_next   = width_reg;
        zfill_next   = zfill_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (s_tvalid)
                begin
                    neg_next     = in_neg;
                    width_next   = in_width;
                    zfill_next   = in_zfill;
                    bit_cnt_next = '0;
                    mag_next     = in_mag;
                    if (in_hex)
                    begin
                        bcd_next   = {16'h0000, in_mag};
                        state_next = FS_FIN;
                    end
                    else
                    begin
                        bcd_next   = '0;
                        state_next = FS_CONV;
                    end
                end
            end
            FS_CONV:
            begin
                bcd_next     = {bcd_adj[pif_pkg::DIGIT_BUS_W-2:0],
                                mag_reg[pif_pkg::VALUE_W-1]};
                mag_next     = {mag_reg[pif_pkg::VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 6'd1;
                if (bit_cnt_reg == 6'd63)
                begin
                    state_next = FS_FIN;
                end
            end
            FS_FIN:
            begin
                if (!q_stat.full)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        neg_reg     <= neg_next;
        width_reg   <= width_next;
        zfill_reg   <= zfill_next;
    end

endmodule

/* hdl/pif_queue.sv */
// Short queue of formatted-number descriptors between front and back part.
// Uses pif_pkg for the descriptor type and depth.
module pif_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pif_pkg::fmt_desc_t  push_desc,
    input  logic                pop,
    output pif_pkg::fmt_desc_t  head_desc,
    output pif_pkg::q_status_t  stat
);

    pif_pkg::fmt_desc_t            mem_reg [pif_pkg::QUEUE_DEPTH];
    logic [pif_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [pif_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [pif_pkg::Q_CNT_W-1:0]   count_reg, count_next;

    assign head_desc  = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == pif_pkg::Q_CNT_W'(pif_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == pif_pkg::Q_PTR_W'(pif_pkg::QUEUE_DEPTH - 1))
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (pop)
        begin
            if (rd_ptr_reg == pif_pkg::Q_PTR_W'(pif_pkg::QUEUE_DEPTH - 1))
            begin
                rd_ptr_next = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

/* hdl/pif_back.sv */
// Back part: walks the descriptor at the queue head and sends one ASCII
// character per transfer through an output register. Uses pif_pkg.
module pif_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  pif_pkg::fmt_desc_t             head_desc,
    input  pif_pkg::q_status_t             q_stat,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // char_out[7:0]
    output logic [pif_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);

    logic [pif_pkg::WIDTH_W-1:0]   pos_reg, pos_next;
    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    out_char_reg, out_char_next;
    logic                          out_last_reg, out_last_next;

    logic [pif_pkg::WIDTH_W-1:0]   lead;
    logic [pif_pkg::WIDTH_W-1:0]   total;
    logic [pif_pkg::WIDTH_W-1:0]   dig_pos;
    logic [pif_pkg::NDIG_W-1:0]    dig_idx;
    logic [3:0]                    dig_val;
    logic [7:0]                    cur_char;
    logic                          is_last;
    logic                          load;

    assign lead    = head_desc.pad + {5'b00000, head_desc.neg};
    assign total   = lead + {1'b0, head_desc.num_digits};
    // Digits leave most significant first, so the index counts down.
    assign dig_pos = total - 6'd1 - pos_reg;
    assign dig_idx = dig_pos[pif_pkg::NDIG_W-1:0];
    assign dig_val = head_desc.digits[{dig_idx, 2'b00} +: 4];
    assign is_last = (pos_reg == total - 6'd1);
    assign load    = !q_stat.empty && (!out_valid_reg || m_tready);
    assign q_pop   = load && is_last;

    always_comb
    begin
        cur_char = pif_pkg::digit_char(dig_val);
        if (head_desc.zero_fill)
        begin
            if (head_desc.neg && pos_reg == '0)
            begin
                cur_char = pif_pkg::CHAR_MINUS;
            end
            else if (pos_reg < lead)
            begin
                cur_char = pif_pkg::CHAR_ZERO;
            end
        end
        else
        begin
            if (pos_reg < head_desc.pad)
            begin
                cur_char = pif_pkg::CHAR_SPACE;
            end
            else if (head_desc.neg && pos_reg == head_desc.pad)
            begin
                cur_char = pif_pkg::CHAR_MINUS;
            end
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_char_next  = cur_char;
            out_last_next  = is_last;
            if (is_last)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 6'd1;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* hdl/padded_integer_formatter_core.sv */
// A value passes the front states (FS_IDLE, FS_CONV in decimal mode only, FS_FIN), the
// queue and the back's output register. Decimal digits come from a shift-and-add-3
// loop over the 64 magnitude bits. The front takes a new value only after pushing the
// last; the slower part sets the sustained rate, with a two-entry queue between them.
// Reset (rst_n, asynchronous, active low) clears the control state; no clearing pass.
`include "padded_integer_formatter_core_assert.svh"

module padded_integer_formatter_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // value[63:0], hex_mode[64], signed_mode[65], min_width[71:66], zero_fill[72]
    input  logic [pif_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // char_out[7:0]
    output logic [pif_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);

    logic                 q_push;
    logic                 q_pop;
    pif_pkg::fmt_desc_t   push_desc;
    pif_pkg::fmt_desc_t   head_desc;
    pif_pkg::q_status_t   q_stat;

    pif_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_desc   (push_desc),
        .q_stat   (q_stat)
    );

    pif_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .head_desc (head_desc),
        .stat      (q_stat)
    );

    pif_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_desc (head_desc),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    `PIF_ASSERT_NEXT(a_front_busy, clk, rst_n, s_tvalid && s_tready, !s_tready, "front busy")
    `PIF_ASSERT(a_no_push_full, clk, rst_n, !(q_push && q_stat.full), "push into full queue")
    `PIF_ASSERT(a_queue_status, clk, rst_n, !(q_stat.full && q_stat.empty), "full and empty")
    `PIF_ASSERT_NEXT(a_pop_with_last, clk, rst_n, q_pop, m_tvalid && m_tlast, "pop without last")

endmodule

/* bench/formatter_char_checker.sv */
// Character checker for the padded integer formatter: watches both stream channels,
// predicts the characters of every accepted value and compares them in order.
// Depends on pif_pkg for the bus widths and the fixed ASCII characters.
module formatter_char_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // value[63:0], hex_mode[64], signed_mode[65], min_width[71:66], zero_fill[72]
    input  logic [pif_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // char_out[7:0]
    input  logic [pif_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          m_tlast,
    output int                            mismatch_count,
    output int                            chars_pending
);

    localparam logic [7:0] LOWER_A     = 8'h61;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } fmt_char_t;

    fmt_char_t char_q [$];

    initial
    begin
        mismatch_count = 0;
        chars_pending  = 0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("formatter_char_checker: at %0t: %s", $time, what);
    endtask

    task automatic push_char(input logic [7:0] ch, input logic last);
        fmt_char_t c;
        c.ch   = ch;
        c.last = last;
        char_q.push_back(c);
    endtask

    // Builds the whole expected string of one transfer and queues it.
    task automatic predict_string(input logic [pif_pkg::S_TDATA_W-1:0] word);
        logic [63:0] mag;
        logic [63:0] base;
        logic [63:0] rem;
        logic        neg;
        logic        zero_fill;
        logic [7:0]  digs [0:23];
        int          nd;
        int          width;
        int          pad;
        int          i;
        mag       = word[63:0];
        base      = word[64] ? 64'd16 : 64'd10;
        neg       = word[65] && word[63];
        width     = int'(word[71:66]);
        zero_fill = word[72];
        if (neg)
        begin
            mag = ~mag + 64'd1;
        end
        // Digits are collected least significant first.
        nd = 0;
        do
        begin
            rem = mag % base;
            if (rem < 64'd10)
            begin
                digs[nd] = pif_pkg::CHAR_ZERO + rem[7:0];
            end
            else
            begin
                digs[nd] = LOWER_A + rem[7:0] - 8'd10;
            end
            nd++;
            mag = mag / base;
        end
        while (mag != 64'd0);
        pad = width - (nd + (neg ? 1 : 0));
        if (pad < 0)
        begin
            pad = 0;
        end
        if (zero_fill)
        begin
            if (neg)
            begin
                push_char(pif_pkg::CHAR_MINUS, 1'b0);
            end
            for (i = 0; i < pad; i++)
            begin
                push_char(pif_pkg::CHAR_ZERO, 1'b0);
            end
        end
        else
        begin
            for (i = 0; i < pad; i++)
            begin
                push_char(pif_pkg::CHAR_SPACE, 1'b0);
            end
            if (neg)
            begin
                push_char(pif_pkg::CHAR_MINUS, 1'b0);
            end
        end
        for (i = nd - 1; i >= 0; i--)
        begin
            push_char(digs[i], i == 0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fmt_char_t expected;
        if (!rst_n)
        begin
            char_q.delete();
            chars_pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (char_q.size() == 0)
                begin
                    report_mismatch($sformatf("character 0x%02h with none expected", m_tdata));
                end
                else
                begin
                    expected = char_q.pop_front();
                    if (m_tdata !== expected.ch)
                    begin
                        report_mismatch($sformatf("char_out 0x%02h, expected 0x%02h",
                                                  m_tdata, expected.ch));
                    end
                    if (m_tlast !== expected.last)
                    begin
                        report_mismatch($sformatf("last %b, expected %b",
                                                  m_tlast, expected.last));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_string(s_tdata);
            end
            chars_pending = char_q.size();
        end
    end

endmodule

/* bench/tb_padded_integer_formatter_core.sv */
// Testbench top for padded_integer_formatter_core: drives values with random gaps
// and output stalls, and gives the verdict from formatter_char_checker's count.
// Depends on pif_pkg, the block and bench/formatter_char_checker.sv.
module tb_padded_integer_formatter_core;

    localparam int      RANDOM_ITEMS = 380;
    localparam int      CALM_ITEMS   = 50;
    localparam int      DRAIN_CYCLES = 80;
    localparam longint  LIMIT_TIME   = 4000000;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [pif_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [pif_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;
    logic                          calm;
    int                            mismatch_count;
    int                            chars_pending;

    always #1 clk = ~clk;

    padded_integer_formatter_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    formatter_char_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending)
    );

    function automatic logic [pif_pkg::S_TDATA_W-1:0] pack_item(input logic [63:0] value,
                                                                 input logic        hex,
                                                                 input logic        sgn,
                                                                 input logic [5:0]  width,
                                                                 input logic        zf);
        return {{(pif_pkg::S_TDATA_W - 73){1'b0}}, zf, width, sgn, hex, value};
    endfunction

    function automatic logic [pif_pkg::S_TDATA_W-1:0] random_item();
        logic [63:0] value;
        logic [5:0]  width;
        int          k;
        case ($urandom_range(0, 9))
            0, 1, 2: value = {$urandom, $urandom};
            3, 4:    value = 64'($urandom_range(0, 999));
            5:       value = -64'($urandom_range(1, 999));
            6:
            begin
                case ($urandom_range(0, 5))
                    0:       value = 64'd0;
                    1:       value = 64'd1;
                    2:       value = 64'hffff_ffff_ffff_ffff;
                    3:       value = 64'h8000_0000_0000_0000;
                    4:       value = 64'h7fff_ffff_ffff_ffff;
                    default: value = 64'h8000_0000_0000_0001;
                endcase
            end
            7:
            begin
                k     = $urandom_range(0, 63);
                value = (64'd1 << k) - 64'($urandom_range(0, 1));
            end
            default: value = 64'($urandom);
        endcase
        // Mostly narrow fields; the widest ones make long strings and slow the run.
        case ($urandom_range(0, 9))
            0, 1:    width = 6'($urandom_range(0, 63));
            2:       width = 6'd63;
            default: width = 6'($urandom_range(0, 24));
        endcase
        return pack_item(value, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         width, 1'($urandom_range(0, 1)));
    endfunction

    // Holds one value on the input until its transfer, after an optional gap.
    task automatic send_value(input logic [pif_pkg::S_TDATA_W-1:0] word);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
    endtask

    initial
    begin
        int n;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        calm     = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_value(pack_item(64'd0, 1'b0, 1'b0, 6'd0, 1'b0));
        send_value(pack_item(64'd0, 1'b1, 1'b1, 6'd5, 1'b1));
        send_value(pack_item(64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, 6'd0, 1'b0));
        send_value(pack_item(64'hffff_ffff_ffff_ffff, 1'b1, 1'b0, 6'd0, 1'b1));
        send_value(pack_item(64'hffff_ffff_ffff_ffff, 1'b0, 1'b1, 6'd4, 1'b0));
        // The most negative value keeps its full magnitude in both bases.
        send_value(pack_item(64'h8000_0000_0000_0000, 1'b0, 1'b1, 6'd0, 1'b0));
        send_value(pack_item(64'h8000_0000_0000_0000, 1'b1, 1'b1, 6'd30, 1'b1));
        send_value(pack_item(64'h8000_0000_0000_0000, 1'b0, 1'b0, 6'd21, 1'b0));
        send_value(pack_item(64'h7fff_ffff_ffff_ffff, 1'b0, 1'b1, 6'd19, 1'b1));
        send_value(pack_item(64'hffff_ffff_ffff_fffb, 1'b0, 1'b1, 6'd10, 1'b0));
        send_value(pack_item(64'hffff_ffff_ffff_fffb, 1'b0, 1'b1, 6'd10, 1'b1));
        send_value(pack_item(64'd12345, 1'b0, 1'b0, 6'd63, 1'b0));
        send_value(pack_item(64'hdead_beef, 1'b1, 1'b0, 6'd63, 1'b1));
        send_value(pack_item(64'habc_def, 1'b1, 1'b1, 6'd3, 1'b0));
        // Widths equal to the string length need no padding.
        send_value(pack_item(64'd7, 1'b0, 1'b0, 6'd1, 1'b1));
        send_value(pack_item(64'hffff_ffff_ffff_fff9, 1'b0, 1'b1, 6'd2, 1'b0));
        send_value(pack_item(64'hffff_ffff_ffff_fff9, 1'b1, 1'b1, 6'd63, 1'b0));
        send_value(pack_item(64'd1, 1'b1, 1'b1, 6'd63, 1'b1));
        send_value(pack_item(64'd9, 1'b0, 1'b0, 6'd2, 1'b1));
        send_value(pack_item(64'd10, 1'b0, 1'b0, 6'd0, 1'b0));
        send_value(pack_item(64'd15, 1'b1, 1'b0, 6'd0, 1'b0));
        send_value(pack_item(64'd16, 1'b1, 1'b0, 6'd2, 1'b0));

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
            begin
                calm <= 1'b1;
            end
            send_value(random_item());
        end
        s_tvalid <= 1'b0;

        while (chars_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb_padded_integer_formatter_core: PASS");
        end
        else
        begin
            $display("tb_padded_integer_formatter_core: FAIL");
        end
        $finish;
    end

    // Output side: stalls in random bursts, none once the run turns calm.
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clk);
        end
    end

    initial
    begin
        #(LIMIT_TIME);
        $display("tb_padded_integer_formatter_core: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/pif_pkg.sv
hdl/pif_front.sv
hdl/pif_queue.sv
hdl/pif_back.sv
hdl/padded_integer_formatter_core.sv
bench/formatter_char_checker.sv
bench/tb_padded_integer_formatter_core.sv
